// ===== hdl/sia_pkg.sv =====
// ----------------------------------------------------------------------------
// sia_pkg
// Shared widths, opcodes and types for the signed integer ALU.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int OP_WIDTH   = 4;
    // Number of quotient bits resolved per divider stage.
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = DATA_WIDTH / DIV_BITS_PER_STAGE;

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_REM  = 4'd4,
        OP_NEG  = 4'd5,
        OP_GT   = 4'd6,
        OP_GE   = 4'd7,
        OP_LT   = 4'd8,
        OP_LE   = 4'd9,
        OP_EQ   = 4'd10,
        OP_NE   = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_PASS = 4'd14,
        OP_NONE = 4'd15
    } t_op;

    // Control carried alongside the divider's datapath.
    typedef struct packed {
        logic valid;
        t_op  op;
        logic neg_q;
        logic neg_r;
        logic dz;
        t_data simple;
    } t_ctl;

endpackage

// ===== hdl/sia_if.sv =====
// ----------------------------------------------------------------------------
// sia_req_if / sia_rsp_if
// Valid/ready channels for ALU requests and results.
// ----------------------------------------------------------------------------
interface sia_req_if;
    logic                                valid;
    logic                                ready;
    logic [sia_pkg::OP_WIDTH-1:0]        op;
    logic signed [sia_pkg::DATA_WIDTH-1:0] left_operand;
    logic signed [sia_pkg::DATA_WIDTH-1:0] right_operand;
    modport source (output valid, op, left_operand, right_operand, input ready);
    modport sink   (input valid, op, left_operand, right_operand, output ready);
endinterface

interface sia_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [sia_pkg::DATA_WIDTH-1:0] result;
    logic                                divide_by_zero;
    modport source (output valid, result, divide_by_zero, input ready);
    modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

// ===== hdl/sia_div_stage.sv =====
// ----------------------------------------------------------------------------
// sia_div_stage
// One pipelined restoring divider stage: DIV_BITS_PER_STAGE quotient bits.
// ----------------------------------------------------------------------------
module sia_div_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  sia_pkg::t_ctl                 i_ctl,
    input  sia_pkg::t_data                i_rem,
    input  sia_pkg::t_data                i_quo,
    input  sia_pkg::t_data                i_div,
    output sia_pkg::t_ctl                 o_ctl,
    output sia_pkg::t_data                o_rem,
    output sia_pkg::t_data                o_quo,
    output sia_pkg::t_data                o_div
);
    sia_pkg::t_data n_rem, n_quo;
    logic [sia_pkg::DATA_WIDTH:0] w_trial;
    sia_pkg::t_ctl r_ctl;
    sia_pkg::t_data r_rem, r_quo, r_div;

    // Partial remainder shifts in one dividend bit (taken from the quotient
    // register's top) per step.
    always_comb begin
        n_rem = i_rem;
        n_quo = i_quo;
        w_trial = '0;
        for (int k = 0; k < sia_pkg::DIV_BITS_PER_STAGE; k++) begin
            w_trial = {n_rem, n_quo[sia_pkg::DATA_WIDTH-1]} - {1'b0, i_div};
            n_quo = {n_quo[sia_pkg::DATA_WIDTH-2:0], ~w_trial[sia_pkg::DATA_WIDTH]};
            if (!w_trial[sia_pkg::DATA_WIDTH]) begin
                n_rem = w_trial[sia_pkg::DATA_WIDTH-1:0];
            end else begin
                n_rem = {n_rem[sia_pkg::DATA_WIDTH-2:0], i_quo[sia_pkg::DATA_WIDTH-1-k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.op     <= i_ctl.op;
            r_ctl.neg_q  <= i_ctl.neg_q;
            r_ctl.neg_r  <= i_ctl.neg_r;
            r_ctl.dz     <= i_ctl.dz;
            r_ctl.simple <= i_ctl.simple;
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_div <= i_div;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_div = r_div;
endmodule

// ===== hdl/sia_front.sv =====
// ----------------------------------------------------------------------------
// sia_front
// Entry stage: simple operations, product, and divider operand preparation.
// ----------------------------------------------------------------------------
module sia_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [sia_pkg::OP_WIDTH-1:0] i_op,
    input  sia_pkg::t_data               i_a,
    input  sia_pkg::t_data               i_b,
    output sia_pkg::t_ctl                o_ctl,
    output sia_pkg::t_data               o_mag_a,
    output sia_pkg::t_data               o_mag_b
);
    sia_pkg::t_data n_simple, w_mag_a, w_mag_b;
    logic w_lt, w_gt;
    sia_pkg::t_ctl r_ctl;
    sia_pkg::t_data r_mag_a, r_mag_b;
    sia_pkg::t_op w_op;

    assign w_op = sia_pkg::t_op'(i_op);
    assign w_lt = $signed(i_a) < $signed(i_b);
    assign w_gt = $signed(i_b) < $signed(i_a);
    assign w_mag_a = i_a[sia_pkg::DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_mag_b = i_b[sia_pkg::DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        case (w_op)
            sia_pkg::OP_ADD:  n_simple = i_a + i_b;
            sia_pkg::OP_SUB:  n_simple = i_a - i_b;
            sia_pkg::OP_NEG:  n_simple = ~i_a + 1'b1;
            sia_pkg::OP_GT:   n_simple = sia_pkg::t_data'(w_gt);
            sia_pkg::OP_GE:   n_simple = sia_pkg::t_data'(!w_lt);
            sia_pkg::OP_LT:   n_simple = sia_pkg::t_data'(w_lt);
            sia_pkg::OP_LE:   n_simple = sia_pkg::t_data'(!w_gt);
            sia_pkg::OP_EQ:   n_simple = sia_pkg::t_data'(i_a == i_b);
            sia_pkg::OP_NE:   n_simple = sia_pkg::t_data'(i_a != i_b);
            sia_pkg::OP_INC:  n_simple = i_a + 1'b1;
            sia_pkg::OP_DEC:  n_simple = i_a - 1'b1;
            sia_pkg::OP_PASS: n_simple = i_a;
            default:          n_simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_valid;
        end
        if (i_en) begin
            r_ctl.op     <= w_op;
            r_ctl.neg_q  <= i_a[sia_pkg::DATA_WIDTH-1] ^ i_b[sia_pkg::DATA_WIDTH-1];
            r_ctl.neg_r  <= i_a[sia_pkg::DATA_WIDTH-1];
            r_ctl.dz     <= (i_b == '0);
            // Multiply is done here in one 32x32 unit; its low half is the result.
            r_ctl.simple <= (w_op == sia_pkg::OP_MUL) ? i_a * i_b : n_simple;
            r_mag_a <= w_mag_a;
            r_mag_b <= w_mag_b;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;
endmodule

// ===== hdl/signed_integer_alu_unit.sv =====
// ----------------------------------------------------------------------------
// signed_integer_alu_unit
// Pipelined signed 32-bit ALU with add, multiply, divide and comparisons.
// ----------------------------------------------------------------------------
//  Channel   Dir  Carries
//  i_req     in   op, left_operand, right_operand
//  o_rsp     out  result, divide_by_zero
//
// A request enters in every cycle with ready high; its result passes through
// one entry stage, eight divider stages of four quotient bits each, and one
// output stage that applies signs and picks the result. All operations take
// the same path so results stay in order. When the output is stalled the
// whole pipeline holds, so nothing is lost or repeated; ready follows the
// output register being empty or being taken. Reset clears only valid bits.
module signed_integer_alu_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sia_req_if.sink  i_req,
    sia_rsp_if.source o_rsp
);
    localparam int NS = sia_pkg::DIV_STAGES;

    logic w_en;
    sia_pkg::t_ctl  w_ctl [NS+1];
    sia_pkg::t_data w_rem [NS+1];
    sia_pkg::t_data w_quo [NS+1];
    sia_pkg::t_data w_div [NS+1];
    sia_pkg::t_data n_result, w_q, w_r;
    logic r_valid, r_dz;
    sia_pkg::t_data r_result;

    // Pipeline advances unless a finished result is waiting and not taken.
    assign w_en = !r_valid || o_rsp.ready;
    assign i_req.ready = w_en;

    sia_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_req.valid),
        .i_op    (i_req.op),
        .i_a     (i_req.left_operand),
        .i_b     (i_req.right_operand),
        .o_ctl   (w_ctl[0]),
        .o_mag_a (w_quo[0]),
        .o_mag_b (w_div[0])
    );
    assign w_rem[0] = '0;

    for (genvar s = 0; s < NS; s++) begin : g_div
        sia_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[s]),
            .i_rem   (w_rem[s]),
            .i_quo   (w_quo[s]),
            .i_div   (w_div[s]),
            .o_ctl   (w_ctl[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_quo   (w_quo[s+1]),
            .o_div   (w_div[s+1])
        );
    end

    // Signs: quotient negative when operand signs differ, remainder follows
    // the dividend. The most negative over minus one wraps naturally.
    assign w_q = w_ctl[NS].neg_q ? (~w_quo[NS] + 1'b1) : w_quo[NS];
    assign w_r = w_ctl[NS].neg_r ? (~w_rem[NS] + 1'b1) : w_rem[NS];

    always_comb begin
        case (w_ctl[NS].op)
            sia_pkg::OP_DIV: n_result = w_ctl[NS].dz ? '0 : w_q;
            sia_pkg::OP_REM: n_result = w_ctl[NS].dz ? '0 : w_r;
            default:         n_result = w_ctl[NS].simple;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_ctl[NS].valid;
        end
        if (w_en) begin
            r_result <= n_result;
            r_dz <= w_ctl[NS].dz &&
                    (w_ctl[NS].op == sia_pkg::OP_DIV || w_ctl[NS].op == sia_pkg::OP_REM);
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.result         = r_result;
    assign o_rsp.divide_by_zero = r_dz;
endmodule
